@@ rtl/rsmp_pkg.sv @@
// Shared types, constants and a helper function of the relay server message parser.
package rsmp_pkg;

    localparam int MAX_BUFFER_BYTES = 4096;
    localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 1);
    localparam int CNT_W = 12;
    localparam int CALC_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] MAX_ERROR_TEXT_RESET = 12'd255;

    localparam int CAND_MATCH = 0;
    localparam int CAND_TUN = 1;
    localparam int CAND_HOST = 2;
    localparam int CAND_ERR = 3;

    localparam int MATCH_ID_POS = 9;
    localparam int TUN_ID_POS = 7;
    localparam int ROOM_CODE_POS = 6;
    localparam int ERR_CODE_POS = 5;
    localparam int ADDR_POS = 11;
    localparam int MATCH_MIN_SIZE = 13;
    localparam int HOST_MIN_SIZE = 10;
    localparam int ERR_MIN_SIZE = 6;
    localparam int TUN_FIXED_BYTES = 12;

    localparam logic [3:0] HDR_LEN [4] = '{4'd9, 4'd7, 4'd6, 4'd5};
    localparam logic [7:0] HDR_TEXT [4][16] = '{
        '{"M", "a", "t", "c", "h", "I", "n", "f", "o",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"T", "u", "n", "I", "n", "f", "o", 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"H", "o", "s", "t", "e", "d", 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"E", "r", "r", "o", "r", 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    typedef enum logic [2:0] {
        KIND_UNKNOWN = 3'd0,
        KIND_MATCH   = 3'd1,
        KIND_TUN     = 3'd2,
        KIND_HOST    = 3'd3,
        KIND_ERR     = 3'd4
    } msg_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        msg_kind_t        msg_kind;
        logic [31:0]      game_id;
        logic [31:0]      room_code;
        logic [7:0]       error_code;
        logic [CNT_W-1:0] text_length;
        logic [CNT_W-1:0] consumed;
    } out_item_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [3:0]       cand;
        logic [31:0]      shift;
        logic [7:0]       ecode;
        logic [CNT_W-1:0] addr_cnt;
        logic             term;
    } buf_state_t;

    function automatic logic [CNT_W-1:0] sat12(input logic [CALC_W-1:0] v);
        return (v > CALC_W'(CNT_MAX)) ? CNT_MAX : v[CNT_W-1:0];
    endfunction

endpackage

@@ rtl/rsmp_byte_engine.sv @@
// Per-buffer state registers and the update that one received byte applies to them.
module rsmp_byte_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  rsmp_pkg::in_item_t   item,
    output rsmp_pkg::buf_state_t state_next
);
    import rsmp_pkg::*;

    buf_state_t state_reg;
    buf_state_t clear_state;
    logic [7:0] b;
    logic [POS_W-1:0] pos;
    logic [1:0] off_match;
    logic [1:0] off_tun;
    logic [1:0] off_host;

    assign b = item.data_byte;
    assign pos = state_reg.pos;
    assign off_match = 2'(pos - POS_W'(MATCH_ID_POS));
    assign off_tun = 2'(pos - POS_W'(TUN_ID_POS));
    assign off_host = 2'(pos - POS_W'(ROOM_CODE_POS));

    always_comb
    begin
        clear_state = '0;
        clear_state.cand = 4'hF;
    end

    always_comb
    begin
        state_next = state_reg;
        if (pos < POS_W'(MAX_BUFFER_BYTES))
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (state_reg.cand[k] && (pos < POS_W'(HDR_LEN[k])) &&
                    (b != HDR_TEXT[k][pos[3:0]]))
                begin
                    state_next.cand[k] = 1'b0;
                end
            end
            if (state_next.cand[CAND_MATCH] && (pos >= POS_W'(MATCH_ID_POS)) &&
                (pos < POS_W'(MATCH_ID_POS + 4)))
            begin
                state_next.shift[{off_match, 3'b000} +: 8] =
                    state_next.shift[{off_match, 3'b000} +: 8] | b;
            end
            if (state_next.cand[CAND_TUN])
            begin
                if ((pos >= POS_W'(TUN_ID_POS)) && (pos < POS_W'(TUN_ID_POS + 4)))
                begin
                    state_next.shift[{off_tun, 3'b000} +: 8] =
                        state_next.shift[{off_tun, 3'b000} +: 8] | b;
                end
                if ((pos >= POS_W'(ADDR_POS)) && !state_reg.term)
                begin
                    if (b == 8'h00)
                    begin
                        state_next.term = 1'b1;
                    end
                    else if (state_reg.addr_cnt != CNT_MAX)
                    begin
                        state_next.addr_cnt = state_reg.addr_cnt + 1'b1;
                    end
                end
            end
            if (state_next.cand[CAND_HOST] && (pos >= POS_W'(ROOM_CODE_POS)) &&
                (pos < POS_W'(ROOM_CODE_POS + 4)))
            begin
                state_next.shift[{off_host, 3'b000} +: 8] =
                    state_next.shift[{off_host, 3'b000} +: 8] | b;
            end
            if (state_next.cand[CAND_ERR] && (pos == POS_W'(ERR_CODE_POS)))
            begin
                state_next.ecode = b;
            end
            state_next.pos = pos + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clear_state;
        end
        else if (take)
        begin
            state_reg <= item.last_byte ? clear_state : state_next;
        end
    end

endmodule

@@ rtl/relay_server_message_parser.sv @@
// Top level of the relay server message parser: result decode, config register, output stage.
//
// The item channel carries one byte of a receive buffer per transfer, with last_byte
// set on the final byte. Every byte updates a few small registers; the bytes of the
// address and error text are only counted. The transfer of a final byte produces one
// result on the result channel in the next cycle: message kind, match id, room code,
// error code, text length and consumed byte count. Other bytes produce no result.
// The block takes one byte per clock cycle; the only limit is the single result
// register, so item_ready drops only while a result is held and result_ready is low.
// Bytes beyond the buffer size limit are counted for nothing but their last_byte flag.
// The cfg channel writes max_error_text, the cap on counted error text bytes; it is
// always ready and should be written only while no buffer is in progress.
// Reset clears the per-buffer state, empties the result register and sets
// max_error_text to 255.
module relay_server_message_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  rsmp_pkg::in_item_t         item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output rsmp_pkg::out_item_t        result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rsmp_pkg::CNT_W-1:0] cfg_data
);
    import rsmp_pkg::*;

    logic take;
    buf_state_t state_next;
    out_item_t result_next;
    out_item_t result_reg;
    logic result_valid_reg;
    logic [CNT_W-1:0] max_error_text_reg;
    logic [CALC_W-1:0] size;
    logic [CALC_W-1:0] err_text;
    logic [CALC_W-1:0] err_capped;

    assign item_ready = !result_valid_reg || result_ready;
    assign take = item_valid && item_ready;
    assign cfg_ready = 1'b1;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    rsmp_byte_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .item       (item),
        .state_next (state_next)
    );

    assign size = CALC_W'(state_next.pos);
    assign err_text = size - CALC_W'(ERR_MIN_SIZE);
    assign err_capped = (err_text > CALC_W'(max_error_text_reg)) ?
                        CALC_W'(max_error_text_reg) : err_text;

    always_comb
    begin
        result_next = '0;
        result_next.msg_kind = KIND_UNKNOWN;
        if (state_next.cand[CAND_MATCH] && (size >= CALC_W'(MATCH_MIN_SIZE)))
        begin
            result_next.msg_kind = KIND_MATCH;
            result_next.game_id = state_next.shift;
            result_next.consumed = CNT_W'(MATCH_MIN_SIZE);
        end
        else if (state_next.cand[CAND_TUN] && state_next.term)
        begin
            result_next.msg_kind = KIND_TUN;
            result_next.game_id = state_next.shift;
            result_next.text_length = state_next.addr_cnt;
            result_next.consumed = sat12(CALC_W'(state_next.addr_cnt) +
                                         CALC_W'(TUN_FIXED_BYTES));
        end
        else if (state_next.cand[CAND_HOST] && (size >= CALC_W'(HOST_MIN_SIZE)))
        begin
            result_next.msg_kind = KIND_HOST;
            result_next.room_code = state_next.shift;
            result_next.consumed = CNT_W'(HOST_MIN_SIZE);
        end
        else if (state_next.cand[CAND_ERR] && (size >= CALC_W'(ERR_MIN_SIZE)))
        begin
            result_next.msg_kind = KIND_ERR;
            result_next.error_code = state_next.ecode;
            result_next.text_length = sat12(err_capped);
            result_next.consumed = sat12(err_capped + CALC_W'(ERR_MIN_SIZE));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            max_error_text_reg <= MAX_ERROR_TEXT_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_error_text_reg <= cfg_data;
            end
            if (take && item.last_byte)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && item.last_byte)
        begin
            result_reg <= result_next;
        end
    end

endmodule

@@ rtl/rsmp_checker.sv @@
// Port-level checks of the relay server message parser and the bind that attaches them.
module rsmp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       item_valid,
    input logic                       item_ready,
    input rsmp_pkg::in_item_t         item,
    input logic                       result_valid,
    input logic                       result_ready,
    input rsmp_pkg::out_item_t        result
);
    import rsmp_pkg::*;

    // A held result must not change until its transfer.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Input back-pressure only comes from a stalled result.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("item_ready low without a stalled result");

    // The final byte of a buffer yields a result in the next cycle.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.last_byte |=> result_valid)
        else $error("no result after final byte");

    // A new result only follows the transfer of a final byte.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready && item.last_byte))
        else $error("result without a final byte");

    // An unknown message reports nothing consumed and empty fields.
    a_unknown_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.msg_kind == KIND_UNKNOWN) |->
        (result.consumed == '0) && (result.game_id == '0) &&
        (result.text_length == '0) && (result.room_code == '0))
        else $error("unknown message with nonzero fields");

endmodule

bind relay_server_message_parser rsmp_checker u_rsmp_checker (.*);
